>>> hw/rtl/slkc_pkg.sv
// Shared types and constants for the sorted LRU key cache.
// Used by slkc_cell and sorted_lru_key_cache; depends on nothing else.
package slkc_pkg;

  localparam int HANDLE_BITS    = 16;
  localparam int IN_KEY_BITS    = 32;
  localparam int IN_TDATA_BITS  = 48;
  localparam int OUT_TDATA_BITS = 16;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_FIN    = 5'b10000
  } slkc_state_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_EVICT_LT,
    CM_EVICT_GT,
    CM_EVICT_EQ
  } slkc_mode_t;

  typedef struct packed {
    slkc_mode_t mode;
    logic       halve;
  } slkc_cmd_t;

endpackage

>>> hw/rtl/slkc_cell.sv
// One entry of the sorted cache: key, handle and age stamp, with the local
// insert, remove and evict moves. Depends on slkc_pkg.
module slkc_cell #(
  parameter int KEY_BITS   = 32,
  parameter int STAMP_BITS = 32,
  parameter int CW         = 4,
  parameter int IW         = 4,
  parameter int IDX        = 0
) (
  input  logic                           clk,
  input  slkc_pkg::slkc_cmd_t            cmd,
  input  logic [CW-1:0]                  fill,
  input  logic [IW-1:0]                  sel,
  input  logic [KEY_BITS-1:0]            key_in,
  input  logic [slkc_pkg::HANDLE_BITS-1:0] handle_in,
  input  logic [STAMP_BITS-1:0]          stamp_in,
  input  logic                           left_lt,
  input  logic                           right_gt,
  input  logic [KEY_BITS-1:0]            left_key,
  input  logic [slkc_pkg::HANDLE_BITS-1:0] left_handle,
  input  logic [STAMP_BITS-1:0]          left_stamp,
  input  logic [KEY_BITS-1:0]            right_key,
  input  logic [slkc_pkg::HANDLE_BITS-1:0] right_handle,
  input  logic [STAMP_BITS-1:0]          right_stamp,
  output logic                           lt_o,
  output logic                           gt_o,
  output logic [KEY_BITS-1:0]            key_o,
  output logic [slkc_pkg::HANDLE_BITS-1:0] handle_o,
  output logic [STAMP_BITS-1:0]          stamp_o
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);
  localparam logic [IW-1:0] IDX_S = IW'(IDX);

  logic [KEY_BITS-1:0]              key_r, key_nxt;
  logic [slkc_pkg::HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [STAMP_BITS-1:0]            stamp_r, stamp_nxt, stamp_sel;
  logic                             valid, below, above;
  logic                             ld_new, ld_left, ld_right;

  always_comb begin
    valid = IDX_C < fill;
    below = IDX_S <= sel;
    above = IDX_S >= sel;
    // Empty cells count as greater than any key so an insert lands at the fill point.
    lt_o = !valid || (key_in < key_r);
    gt_o = valid && (key_in > key_r);
    ld_new   = 1'b0;
    ld_left  = 1'b0;
    ld_right = 1'b0;
    unique case (cmd.mode)
      slkc_pkg::CM_INSERT: begin
        ld_new  = lt_o && !left_lt;
        ld_left = left_lt;
      end
      slkc_pkg::CM_REMOVE: begin
        ld_right = above;
      end
      slkc_pkg::CM_EVICT_LT: begin
        ld_new  = below && lt_o && !left_lt;
        ld_left = below && left_lt;
      end
      slkc_pkg::CM_EVICT_GT: begin
        ld_new   = above && gt_o && !right_gt;
        ld_right = above && right_gt;
      end
      slkc_pkg::CM_EVICT_EQ: begin
        ld_new = IDX_S == sel;
      end
      default: begin
      end
    endcase
    key_nxt   = key_r;
    handle_nxt = handle_r;
    stamp_sel = stamp_r;
    if (ld_new) begin
      key_nxt    = key_in;
      handle_nxt = handle_in;
      stamp_sel  = stamp_in;
    end else if (ld_left) begin
      key_nxt    = left_key;
      handle_nxt = left_handle;
      stamp_sel  = left_stamp;
    end else if (ld_right) begin
      key_nxt    = right_key;
      handle_nxt = right_handle;
      stamp_sel  = right_stamp;
    end
    stamp_nxt = cmd.halve ? (stamp_sel >> 1) : stamp_sel;
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    handle_r <= handle_nxt;
    stamp_r  <= stamp_nxt;
  end

  assign key_o    = key_r;
  assign handle_o = handle_r;
  assign stamp_o  = stamp_r;

endmodule

>>> hw/rtl/sorted_lru_key_cache.sv
// Take: a binary search loop over the filled entries, then a remove shift on a hit.
// Add, not full: an insert shift. Add, full: the oldest-stamp scan, then an evicting shift.
// One request is in flight at a time; the next word is taken while a result waits.
// Reset clears the fill count, the age clock, the sequencer and the output valid; entries hold no reset.
// Holds the sequencer and the row of slkc_cell entries; depends on slkc_pkg.
module sorted_lru_key_cache #(
  parameter int CACHE_ENTRIES = 10,
  parameter int KEY_BITS      = 32,
  parameter int STAMP_BITS    = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [slkc_pkg::IN_TDATA_BITS-1:0]  in_tdata,   // key[31:0], handle[47:32]
  input  logic [0:0]                          in_tuser,   // req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [slkc_pkg::OUT_TDATA_BITS-1:0] out_tdata,  // out_handle[15:0]
  output logic [1:0]                          out_tuser   // hit, evicted
);

  localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CW = $clog2(CACHE_ENTRIES + 1);
  localparam int HB = slkc_pkg::HANDLE_BITS;
  localparam logic [CW-1:0] FULL_C = CW'(CACHE_ENTRIES);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

  slkc_pkg::slkc_state_t state_r, state_nxt;
  slkc_pkg::slkc_cmd_t   cmd;

  logic [CW-1:0]         fill_r, fill_nxt;
  logic [STAMP_BITS-1:0] age_r, age_nxt;
  logic                  req_add_r, req_add_nxt;
  logic                  full_r, full_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [HB-1:0]         handle_r, handle_nxt;
  logic [CW-1:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]         scan_r, scan_nxt;
  logic [IW-1:0]         sel_r, sel_nxt;
  logic [STAMP_BITS-1:0] best_r, best_nxt;
  logic                  res_hit_r, res_hit_nxt, res_evict_r, res_evict_nxt;
  logic [HB-1:0]         res_handle_r, res_handle_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_hit_nxt, out_evict_r, out_evict_nxt;
  logic [HB-1:0]         out_handle_r, out_handle_nxt;

  logic [63:0]           key_wide;
  logic [KEY_BITS-1:0]   key_in;
  logic [CW:0]           mid_sum;
  logic [IW-1:0]         mid;
  logic [IW-1:0]         rd_idx;
  logic [KEY_BITS-1:0]   rd_key;
  logic [HB-1:0]         rd_handle;
  logic [STAMP_BITS-1:0] rd_stamp;

  logic [KEY_BITS-1:0]   cell_key   [CACHE_ENTRIES];
  logic [HB-1:0]         cell_handle[CACHE_ENTRIES];
  logic [STAMP_BITS-1:0] cell_stamp [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] cell_lt, cell_gt;

  assign key_wide = {32'b0, in_tdata[slkc_pkg::IN_KEY_BITS-1:0]};
  assign key_in   = key_wide[KEY_BITS-1:0];
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - (CW + 1)'(1);
  assign mid      = mid_sum[IW:1];

  always_comb begin
    rd_key    = '0;
    rd_handle = '0;
    rd_stamp  = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      if (rd_idx == IW'(i)) begin
        rd_key    = cell_key[i];
        rd_handle = cell_handle[i];
        rd_stamp  = cell_stamp[i];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    age_nxt        = age_r;
    req_add_nxt    = req_add_r;
    full_nxt       = full_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    scan_nxt       = scan_r;
    sel_nxt        = sel_r;
    best_nxt       = best_r;
    res_hit_nxt    = res_hit_r;
    res_evict_nxt  = res_evict_r;
    res_handle_nxt = res_handle_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_evict_nxt  = out_evict_r;
    out_handle_nxt = out_handle_r;
    cmd.mode       = slkc_pkg::CM_HOLD;
    cmd.halve      = 1'b0;
    rd_idx         = sel_r;
    unique case (state_r)
      slkc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          key_nxt        = key_in;
          handle_nxt     = in_tdata[slkc_pkg::IN_KEY_BITS +: HB];
          req_add_nxt    = in_tuser[0];
          full_nxt       = fill_r == FULL_C;
          res_hit_nxt    = 1'b0;
          res_evict_nxt  = 1'b0;
          res_handle_nxt = '0;
          lo_nxt         = '0;
          hi_nxt         = fill_r;
          scan_nxt       = CW'(1);
          sel_nxt        = '0;
          best_nxt       = cell_stamp[0];
          if (!in_tuser[0]) begin
            state_nxt = slkc_pkg::ST_SEARCH;
          end else if (fill_r == FULL_C) begin
            state_nxt = slkc_pkg::ST_SCAN;
          end else begin
            state_nxt = slkc_pkg::ST_SHIFT;
          end
        end
      end
      slkc_pkg::ST_SEARCH: begin
        rd_idx = mid;
        if (hi_r <= lo_r) begin
          state_nxt = slkc_pkg::ST_FIN;
        end else if (key_r < rd_key) begin
          hi_nxt = CW'(mid);
        end else if (key_r > rd_key) begin
          lo_nxt = CW'(mid) + CW'(1);
        end else begin
          res_hit_nxt    = 1'b1;
          res_handle_nxt = rd_handle;
          sel_nxt        = mid;
          state_nxt      = slkc_pkg::ST_SHIFT;
        end
      end
      slkc_pkg::ST_SCAN: begin
        rd_idx = scan_r[IW-1:0];
        if (scan_r < FULL_C) begin
          if (rd_stamp < best_r) begin
            best_nxt = rd_stamp;
            sel_nxt  = scan_r[IW-1:0];
          end
          scan_nxt = scan_r + CW'(1);
        end else begin
          state_nxt = slkc_pkg::ST_SHIFT;
        end
      end
      slkc_pkg::ST_SHIFT: begin
        state_nxt = slkc_pkg::ST_FIN;
        if (req_add_r) begin
          cmd.halve = age_r == STAMP_MAX;
          age_nxt   = (age_r == STAMP_MAX) ? (age_r >> 1) : (age_r + STAMP_BITS'(1));
          if (full_r) begin
            res_evict_nxt  = 1'b1;
            res_handle_nxt = rd_handle;
            if (key_r < rd_key) begin
              cmd.mode = slkc_pkg::CM_EVICT_LT;
            end else if (key_r > rd_key) begin
              cmd.mode = slkc_pkg::CM_EVICT_GT;
            end else begin
              cmd.mode = slkc_pkg::CM_EVICT_EQ;
            end
          end else begin
            cmd.mode = slkc_pkg::CM_INSERT;
            fill_nxt = fill_r + CW'(1);
          end
        end else begin
          cmd.mode = slkc_pkg::CM_REMOVE;
          fill_nxt = fill_r - CW'(1);
        end
      end
      slkc_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = res_hit_r;
          out_evict_nxt  = res_evict_r;
          out_handle_nxt = res_handle_r;
          state_nxt      = slkc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slkc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slkc_pkg::ST_IDLE;
      fill_r      <= '0;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      age_r       <= age_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_add_r    <= req_add_nxt;
    full_r       <= full_nxt;
    key_r        <= key_nxt;
    handle_r     <= handle_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    scan_r       <= scan_nxt;
    sel_r        <= sel_nxt;
    best_r       <= best_nxt;
    res_hit_r    <= res_hit_nxt;
    res_evict_r  <= res_evict_nxt;
    res_handle_r <= res_handle_nxt;
    out_hit_r    <= out_hit_nxt;
    out_evict_r  <= out_evict_nxt;
    out_handle_r <= out_handle_nxt;
  end

  for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_cell
    logic                  l_lt, r_gt;
    logic [KEY_BITS-1:0]   l_key, r_key;
    logic [HB-1:0]         l_handle, r_handle;
    logic [STAMP_BITS-1:0] l_stamp, r_stamp;

    if (i == 0) begin : g_first
      assign l_lt     = 1'b0;
      assign l_key    = '0;
      assign l_handle = '0;
      assign l_stamp  = '0;
    end else begin : g_left
      assign l_lt     = cell_lt[i-1];
      assign l_key    = cell_key[i-1];
      assign l_handle = cell_handle[i-1];
      assign l_stamp  = cell_stamp[i-1];
    end

    if (i == CACHE_ENTRIES - 1) begin : g_last
      assign r_gt     = 1'b0;
      assign r_key    = '0;
      assign r_handle = '0;
      assign r_stamp  = '0;
    end else begin : g_right
      assign r_gt     = cell_gt[i+1];
      assign r_key    = cell_key[i+1];
      assign r_handle = cell_handle[i+1];
      assign r_stamp  = cell_stamp[i+1];
    end

    slkc_cell #(
      .KEY_BITS  (KEY_BITS),
      .STAMP_BITS(STAMP_BITS),
      .CW        (CW),
      .IW        (IW),
      .IDX       (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .fill        (fill_r),
      .sel         (sel_r),
      .key_in      (key_r),
      .handle_in   (handle_r),
      .stamp_in    (age_r),
      .left_lt     (l_lt),
      .right_gt    (r_gt),
      .left_key    (l_key),
      .left_handle (l_handle),
      .left_stamp  (l_stamp),
      .right_key   (r_key),
      .right_handle(r_handle),
      .right_stamp (r_stamp),
      .lt_o        (cell_lt[i]),
      .gt_o        (cell_gt[i]),
      .key_o       (cell_key[i]),
      .handle_o    (cell_handle[i]),
      .stamp_o     (cell_stamp[i])
    );
  end

  assign in_tready  = state_r == slkc_pkg::ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_handle_r;
  assign out_tuser  = {out_evict_r, out_hit_r};

endmodule
